// ===== src/bsl2_pkg.sv =====
package bsl2_pkg;

  // Element and sum widths, and the number of elements between bound checks
  localparam int unsigned ElemWidth     = 16;
  localparam int unsigned SumWidth      = 48;
  localparam int unsigned CheckInterval = 64;

  // Derived widths
  localparam int unsigned DiffWidth = ElemWidth + 1;
  localparam int unsigned SqWidth   = 2 * DiffWidth;
  localparam int unsigned PosWidth  = $clog2(CheckInterval);

  localparam logic [PosWidth-1:0] PosLast = PosWidth'(CheckInterval - 1);

  // Squared difference item passed from the front end to the accumulator
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [SqWidth-1:0] sq;
  } sq_item_t;

endpackage

// ===== src/bsl2_square.sv =====
module bsl2_square (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [bsl2_pkg::ElemWidth-1:0] elem_a_i,
  input  logic signed [bsl2_pkg::ElemWidth-1:0] elem_b_i,
  input  logic                            last_elem_i,
  output bsl2_pkg::sq_item_t              sq_item_o,
  input  logic                            take_i
);
  import bsl2_pkg::*;

  logic                        in_valid_q;
  logic signed [ElemWidth-1:0] a_q, b_q;
  logic                        last_q;
  logic                        sq_valid_q, sq_last_q;
  logic [SqWidth-1:0]          sq_q;

  logic                        sq_free, in_move, in_free;
  logic signed [DiffWidth-1:0] diff;
  logic [DiffWidth-1:0]        mag;
  logic [SqWidth-1:0]          sq_d;

  // Slot handshake: each register refills when empty or moving on
  assign sq_free    = !sq_valid_q || take_i;
  assign in_move    = in_valid_q && sq_free;
  assign in_free    = !in_valid_q || in_move;
  assign in_stall_o = !in_free;

  // Difference, magnitude and square
  always_comb begin
    diff = DiffWidth'(a_q) - DiffWidth'(b_q);
    mag  = diff[DiffWidth-1] ? DiffWidth'(-diff) : DiffWidth'(diff);
    sq_d = SqWidth'(mag) * SqWidth'(mag);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      sq_valid_q <= 1'b0;
    end else begin
      if (in_free) in_valid_q <= in_valid_i;
      if (sq_free) sq_valid_q <= in_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      a_q    <= elem_a_i;
      b_q    <= elem_b_i;
      last_q <= last_elem_i;
    end
    if (in_move) begin
      sq_q      <= sq_d;
      sq_last_q <= last_q;
    end
  end

  assign sq_item_o.valid = sq_valid_q;
  assign sq_item_o.last  = sq_last_q;
  assign sq_item_o.sq    = sq_q;

endmodule

// ===== src/bsl2_accum.sv =====
module bsl2_accum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsl2_pkg::SumWidth-1:0]  cfg_data_i,
  input  bsl2_pkg::sq_item_t             sq_item_i,
  output logic                           take_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bsl2_pkg::SumWidth-1:0]  distance_o,
  output logic                           over_bound_o
);
  import bsl2_pkg::*;

  logic [SumWidth-1:0] bound_q;
  logic [SumWidth-1:0] sum_q;
  logic [PosWidth-1:0] pos_q;
  logic                drop_q;
  logic                out_valid_q;
  logic [SumWidth-1:0] dist_q;
  logic                over_q;

  logic [SumWidth:0]   sum_ext;
  logic [SumWidth-1:0] sum_sat;
  logic                check, over, produce, out_free;

  // Saturating accumulate and bound compare
  always_comb begin
    sum_ext  = {1'b0, sum_q} + (SumWidth+1)'(sq_item_i.sq);
    sum_sat  = sum_ext[SumWidth] ? {SumWidth{1'b1}} : sum_ext[SumWidth-1:0];
    check    = (pos_q == PosLast);
    over     = (sum_sat > bound_q);
    produce  = sq_item_i.valid && !drop_q && (sq_item_i.last || (check && over));
    out_free = !out_valid_q || !out_stall_i;
    take_o   = sq_item_i.valid && (!produce || out_free);
  end

  // Bound register, vector state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q     <= {SumWidth{1'b1}};
      sum_q       <= '0;
      pos_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) bound_q <= cfg_data_i;
      if (take_o) begin
        if (sq_item_i.last) begin
          sum_q  <= '0;
          pos_q  <= '0;
          drop_q <= 1'b0;
        end else if (!drop_q) begin
          sum_q <= sum_sat;
          pos_q <= check ? '0 : pos_q + 1'b1;
          if (produce) drop_q <= 1'b1;
        end
      end
      if (out_free) out_valid_q <= take_o && produce;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_free && take_o && produce) begin
      dist_q <= sum_sat;
      over_q <= over;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign distance_o   = dist_q;
  assign over_bound_o = over_q;

endmodule

// ===== src/bounded_squared_l2_distance_core.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------
// input    | in_valid_i/in_stall_o  | elem_a_i, elem_b_i, last_elem_i
// output   | out_valid_o/out_stall_i| distance_o, over_bound_o
// config   | cfg_we_i               | cfg_data_i (distance bound)
//
// One item per cycle while no stall holds the flow; an accepted item passes the
// input register and the squaring register, then is accumulated into the
// result register.
// Reset clears all valids and the vector state; the bound resets to all ones.
// A stalled result holds; items that give no result keep flowing behind it,
// and input stalls only once every stage before the result register is full.
module bounded_squared_l2_distance_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bsl2_pkg::SumWidth-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [bsl2_pkg::ElemWidth-1:0] elem_a_i,
  input  logic signed [bsl2_pkg::ElemWidth-1:0] elem_b_i,
  input  logic                                  last_elem_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [bsl2_pkg::SumWidth-1:0]         distance_o,
  output logic                                  over_bound_o
);
  import bsl2_pkg::*;

  sq_item_t sq_item;
  logic     take;

  // Difference and square
  bsl2_square u_square (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .elem_a_i    (elem_a_i),
    .elem_b_i    (elem_b_i),
    .last_elem_i (last_elem_i),
    .sq_item_o   (sq_item),
    .take_i      (take)
  );

  // Accumulate, check and emit
  bsl2_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .sq_item_i    (sq_item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .distance_o   (distance_o),
    .over_bound_o (over_bound_o)
  );

endmodule

// ===== src/bsl2_checker.sv =====
module bsl2_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  cfg_we_i,
  input logic [bsl2_pkg::SumWidth-1:0]         cfg_data_i,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic signed [bsl2_pkg::ElemWidth-1:0] elem_a_i,
  input logic signed [bsl2_pkg::ElemWidth-1:0] elem_b_i,
  input logic                                  last_elem_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic [bsl2_pkg::SumWidth-1:0]         distance_o,
  input logic                                  over_bound_o
);
  import bsl2_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(distance_o) && $stable(over_bound_o))
    else $error("stalled result changed");

  // Input backs up only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // Flagged distance is above a bound of at least zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && over_bound_o |-> distance_o != '0)
    else $error("over_bound with zero distance");

  // No result shown in the cycle after a reset edge
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind bounded_squared_l2_distance_core bsl2_checker u_checker (.*);

// ===== bench/bsl2_distance_checker.sv =====
module bsl2_distance_checker
  import bsl2_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SumWidth-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [ElemWidth-1:0] elem_a_i,
  input  logic [ElemWidth-1:0] elem_b_i,
  input  logic                 last_elem_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [SumWidth-1:0]  distance_i,
  input  logic                 over_bound_i,
  output int unsigned          pending_o,
  output int unsigned          fail_count_o
);

  localparam logic [SumWidth-1:0] SumMax       = '1;
  localparam int unsigned         ReportLimit  = 10;

  typedef struct packed {
    logic [SumWidth-1:0] distance;
    logic                over_bound;
  } dist_result_t;

  // Predicted distances still waiting for the block to produce them
  dist_result_t        expected_dist_q[$];

  // Local copy of the bound register and the per-vector state
  logic [SumWidth-1:0] bound_q;
  logic [SumWidth-1:0] sum_q;
  int unsigned         elems_since_check;
  logic                dropping_q;
  int unsigned         mismatches = 0;

  task automatic clear_vector();
    sum_q             = '0;
    elems_since_check = 0;
    dropping_q        = 1'b0;
  endtask

  // Accumulate one element pair and queue a distance when one is due
  task automatic accumulate_pair(input logic [ElemWidth-1:0] a, input logic [ElemWidth-1:0] b,
                                 input logic last);
    logic [DiffWidth-1:0] diff;
    logic [DiffWidth-1:0] mag;
    logic [SqWidth-1:0]   sq;
    logic [SumWidth:0]    wide;
    logic                 check;
    logic                 over;
    dist_result_t         res;
    if (dropping_q) begin
      // rest of an early-exit vector is swallowed up to its last element
      if (last) clear_vector();
      return;
    end
    diff  = {a[ElemWidth-1], a} - {b[ElemWidth-1], b};
    mag   = diff[DiffWidth-1] ? -diff : diff;
    sq    = mag * mag;
    wide  = {1'b0, sum_q} + sq;
    sum_q = wide[SumWidth] ? SumMax : wide[SumWidth-1:0];
    elems_since_check++;
    check = 1'b0;
    if (elems_since_check >= CheckInterval) begin
      elems_since_check = 0;
      check             = 1'b1;
    end
    over = sum_q > bound_q;
    if (last || (check && over)) begin
      res.distance   = sum_q;
      res.over_bound = over;
      expected_dist_q.push_back(res);
      if (last) clear_vector();
      else dropping_q = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dist_result_t want;
    if (!rst_ni) begin
      bound_q = SumMax;
      clear_vector();
      expected_dist_q.delete();
    end else begin
      if (cfg_we_i) bound_q = cfg_data_i;

      // Compare each accepted result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_dist_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("[%0t] unexpected result: distance %0d over_bound %0b", $realtime,
                     distance_i, over_bound_i);
        end else begin
          want = expected_dist_q.pop_front();
          if (want.distance !== distance_i || want.over_bound !== over_bound_i) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("[%0t] mismatch: distance exp %0d got %0d, over_bound exp %0b got %0b",
                       $realtime, want.distance, distance_i, want.over_bound, over_bound_i);
          end
        end
      end

      if (in_valid_i && !in_stall_i) accumulate_pair(elem_a_i, elem_b_i, last_elem_i);
    end
    pending_o    <= expected_dist_q.size();
    fail_count_o <= mismatches;
  end

endmodule

// ===== bench/tb_bounded_squared_l2_distance_core.sv =====
module tb_bounded_squared_l2_distance_core;
  import bsl2_pkg::*;

  localparam logic [SumWidth-1:0] SumMax      = '1;
  localparam int unsigned         DrainCycles = 8;
  localparam int unsigned         HoldCycles  = 150;
  localparam int unsigned         QuietLimit  = 2000;

  typedef enum int {ELEM_FULL, ELEM_SMALL, ELEM_EXTREME, ELEM_MAXDIFF} elem_kind_e;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [SumWidth-1:0]         cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  logic signed [ElemWidth-1:0] elem_a    = '0;
  logic signed [ElemWidth-1:0] elem_b    = '0;
  logic                        last_elem = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [SumWidth-1:0]         distance;
  logic                        over_bound;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left    = 0;
  logic        hold_req     = 1'b0;
  logic        hold_ack     = 1'b0;

  always #2 clk = ~clk;

  bounded_squared_l2_distance_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .elem_a_i     (elem_a),
    .elem_b_i     (elem_b),
    .last_elem_i  (last_elem),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .distance_o   (distance),
    .over_bound_o (over_bound)
  );

  bsl2_distance_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .elem_a_i     (elem_a),
    .elem_b_i     (elem_b),
    .last_elem_i  (last_elem),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .distance_i   (distance),
    .over_bound_i (over_bound),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Result side: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [ElemWidth-1:0] pick_elem(elem_kind_e kind);
    case (kind)
      ELEM_SMALL: return ElemWidth'(int'($urandom_range(0, 15)) - 8);
      ELEM_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7fff;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return ElemWidth'($urandom);
    endcase
  endfunction

  function automatic logic [SumWidth-1:0] pick_bound();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return SumMax;
      2:       return SumWidth'($urandom);
      3:       return SumWidth'({$urandom, $urandom});
      default: return SumWidth'($urandom) << $urandom_range(0, 16);
    endcase
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_elem(input logic [ElemWidth-1:0] a, input logic [ElemWidth-1:0] b,
                           input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    elem_a    <= a;
    elem_b    <= b;
    last_elem <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering, wait for every predicted distance, then let the pipe empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_bound(input logic [SumWidth-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // One vector; optionally pause at element cut and load a new bound
  task automatic send_vector(input int len, input elem_kind_e kind, input int cut,
                             input logic [SumWidth-1:0] cut_bound);
    logic [ElemWidth-1:0] a;
    logic [ElemWidth-1:0] b;
    for (int i = 0; i < len; i++) begin
      if (i == cut) begin
        wait_drained();
        write_bound(cut_bound);
      end
      if (kind == ELEM_MAXDIFF) begin
        a = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        b = ~a;
      end else begin
        a = pick_elem(kind);
        b = pick_elem(kind);
      end
      send_elem(a, b, i == len - 1);
    end
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned start;
    int          len;
    int          cut;
    int unsigned r;
    elem_kind_e  kind;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
        write_bound(pick_bound());
      end
      r = $urandom_range(0, 99);
      if (r < 55)      len = $urandom_range(1, 16);
      else if (r < 85) len = $urandom_range(60, 70);
      else             len = $urandom_range(100, 200);
      r = $urandom_range(0, 19);
      if (r == 0)      kind = ELEM_MAXDIFF;
      else if (r < 4)  kind = ELEM_SMALL;
      else if (r < 7)  kind = ELEM_EXTREME;
      else             kind = ELEM_FULL;
      cut = ($urandom_range(0, 15) == 0) ? $urandom_range(0, len - 1) : -1;
      send_vector(len, kind, cut, pick_bound());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender gaps light, receiver stalls heavy
    send_gap_pct = 32;
    recv_gap_pct <= 82;

    // Single-element vectors at the reset bound, extreme, small and zero differences
    send_elem(16'h7fff, 16'h8000, 1'b1);
    send_elem(16'h8000, 16'h7fff, 1'b1);
    send_elem(16'h0000, 16'h0000, 1'b1);
    send_elem(16'hffff, 16'hffff, 1'b1);
    send_elem(16'h0005, 16'hfffd, 1'b1);
    // Zero bound: any non-zero distance is over, zero is not
    wait_drained();
    write_bound('0);
    send_elem(16'h0001, 16'h0000, 1'b1);
    send_elem(16'h0000, 16'h0000, 1'b1);
    // Check falling on the last element, over and not over
    send_vector(64, ELEM_EXTREME, -1, '0);
    wait_drained();
    write_bound(SumMax);
    send_vector(64, ELEM_FULL, -1, '0);
    // Early exit at the first check, then the tail is dropped
    wait_drained();
    write_bound('0);
    send_vector(70, ELEM_FULL, -1, '0);
    // Bound lowered part way through a vector
    wait_drained();
    write_bound(SumMax);
    send_vector(100, ELEM_FULL, 30, 48'd1000);

    run_random(550);

    // Sender gaps heavy, receiver stalls light
    wait_drained();
    send_gap_pct = 82;
    recv_gap_pct <= 32;
    run_random(550);

    // No gaps from here on
    wait_drained();
    send_gap_pct = 0;
    recv_gap_pct <= 0;

    // Largest differences over two check intervals, staying under a high bound
    write_bound(SumMax - 1);
    send_vector(130, ELEM_MAXDIFF, -1, '0);

    // Long receiver hold-off while single-element vectors keep coming
    wait_drained();
    hold_req <= ~hold_req;
    repeat (40) send_vector(1, ELEM_FULL, -1, '0);
    wait_drained();

    run_random(450);

    wait_drained();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
